FILE: rtl/core/ebc_pkg.sv
// ----------------------------------------------------------------------------
// ebc_pkg - shared definitions for the 8-bit execute step
// Opcodes, flag positions, reset values, the result struct and the operand
// address selection used by the input stage.
// ----------------------------------------------------------------------------
package ebc_pkg;

    localparam int REG_AW = 3;
    localparam int DATA_W = 8;
    localparam int FLAG_W = 6;
    localparam int STOP_W = 2;

    // opcodes, instruction bits 15..11
    localparam logic [4:0] OP_NOP  = 5'h00;
    localparam logic [4:0] OP_IN   = 5'h01;
    localparam logic [4:0] OP_OUT  = 5'h02;
    localparam logic [4:0] OP_MOV  = 5'h03;
    localparam logic [4:0] OP_LDI  = 5'h04;
    localparam logic [4:0] OP_JMP  = 5'h05;
    localparam logic [4:0] OP_JZ   = 5'h06;
    localparam logic [4:0] OP_JNZ  = 5'h07;
    localparam logic [4:0] OP_JC   = 5'h08;
    localparam logic [4:0] OP_JO   = 5'h09;
    localparam logic [4:0] OP_JEOI = 5'h0A;
    localparam logic [4:0] OP_HALT = 5'h0B;
    localparam logic [4:0] OP_INC  = 5'h0C;
    localparam logic [4:0] OP_DEC  = 5'h0D;
    localparam logic [4:0] OP_ADD  = 5'h0E;
    localparam logic [4:0] OP_SUB  = 5'h0F;
    localparam logic [4:0] OP_XOR  = 5'h10;
    localparam logic [4:0] OP_OR   = 5'h11;
    localparam logic [4:0] OP_AND  = 5'h12;
    localparam logic [4:0] OP_SHR  = 5'h13;
    localparam logic [4:0] OP_SHL  = 5'h14;

    // flag bit positions
    localparam int FLAG_C   = 0;
    localparam int FLAG_EOI = 2;
    localparam int FLAG_Z   = 4;
    localparam int FLAG_O   = 5;

    localparam logic [FLAG_W-1:0] FLAGS_RESET = 6'b000010;

    // stop codes
    localparam logic [STOP_W-1:0] STOP_RUN   = 2'd0;
    localparam logic [STOP_W-1:0] STOP_HALT  = 2'd1;
    localparam logic [STOP_W-1:0] STOP_FAULT = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] next_pc;
        logic [FLAG_W-1:0] flags;
        logic              write_valid;
        logic [REG_AW-1:0] write_index;
        logic [DATA_W-1:0] write_value;
        logic              out_valid;
        logic [DATA_W-1:0] out_byte;
        logic              in_taken;
        logic [STOP_W-1:0] run_status;
    } result_t;

    // first operand: d for inc/dec, s for single-source ops, else by mode
    function automatic logic [REG_AW-1:0] opnd_a_addr(input logic [15:0] instr);
        logic [4:0] op;
        op = instr[15:11];
        case (op)
            OP_INC, OP_DEC:                 opnd_a_addr = instr[10:8];
            OP_OUT, OP_MOV, OP_SHR, OP_SHL: opnd_a_addr = instr[6:4];
            default:                        opnd_a_addr = instr[7] ? instr[6:4] : instr[10:8];
        endcase
    endfunction

    // second operand: t in three-register mode, s in two-register mode
    function automatic logic [REG_AW-1:0] opnd_b_addr(input logic [15:0] instr);
        opnd_b_addr = instr[7] ? instr[2:0] : instr[6:4];
    endfunction

endpackage

FILE: rtl/core/ebc_cmd_if.sv
// ----------------------------------------------------------------------------
// ebc_cmd_if - instruction channel
// Valid/ready channel carrying one instruction word and the input byte.
// ----------------------------------------------------------------------------
interface ebc_cmd_if;
    logic        valid;
    logic        ready;
    logic [15:0] instruction;
    logic [7:0]  in_byte;
    logic        in_available;

    modport source (output valid, output instruction, output in_byte,
                    output in_available, input ready);
    modport sink   (input valid, input instruction, input in_byte,
                    input in_available, output ready);
endinterface

FILE: rtl/core/ebc_rsp_if.sv
// ----------------------------------------------------------------------------
// ebc_rsp_if - result channel
// Valid/ready channel carrying the outcome of one executed instruction.
// ----------------------------------------------------------------------------
interface ebc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] next_pc;
    logic [5:0] flags;
    logic       write_valid;
    logic [2:0] write_index;
    logic [7:0] write_value;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       in_taken;
    logic [1:0] run_status;

    modport source (output valid, output next_pc, output flags, output write_valid,
                    output write_index, output write_value, output out_valid,
                    output out_byte, output in_taken, output run_status, input ready);
    modport sink   (input valid, input next_pc, input flags, input write_valid,
                    input write_index, input write_value, input out_valid,
                    input out_byte, input in_taken, input run_status, output ready);
endinterface

FILE: rtl/core/eight_bit_cpu_execute_step.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_step - one instruction per word on an 8-bit machine
// Input stage with operand fetch, combinational execute, registered result.
// ----------------------------------------------------------------------------
// One instruction word is taken per clock cycle, sustained unless the result
// side stalls. On acceptance the word is registered together with both
// register-file operands (the operand fetch sees any register write made in
// that same cycle, so dependent instructions may follow back to back). When
// the output buffer is free or draining, the execute logic works out the
// result from those operands and the current pc, flags and stop code, writes
// the register file and loads the result register. The result register is a
// one-word output buffer: a new word is still accepted while a result waits,
// and both sides stall only when the result waits and the input stage is
// also full. After halt or an unknown opcode every later word is answered
// with the held pc, flags and stop code and changes nothing until reset.
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute_step (
    input  logic        clk,
    input  logic        rst_n,
    ebc_cmd_if.sink     cmd,
    ebc_rsp_if.source   rsp
);

    // input stage
    logic                         in_full_reg;
    logic                         in_full_next;
    logic [15:0]                  instr_reg;
    logic [ebc_pkg::DATA_W-1:0]   in_byte_reg;
    logic                         in_avail_reg;

    // output buffer
    logic                         out_full_reg;
    logic                         out_full_next;
    ebc_pkg::result_t             res_reg;

    // architectural state other than the register file
    logic [ebc_pkg::DATA_W-1:0]   pc_reg;
    logic [ebc_pkg::FLAG_W-1:0]   flags_reg;
    logic [ebc_pkg::STOP_W-1:0]   stop_reg;

    logic                         cmd_acc;
    logic                         exec_go;
    logic [ebc_pkg::DATA_W-1:0]   opa;
    logic [ebc_pkg::DATA_W-1:0]   opb;
    ebc_pkg::result_t             exec_res;

    // execute fires when a word is staged and the buffer is free or draining
    assign exec_go   = in_full_reg && (!out_full_reg || rsp.ready);
    assign cmd.ready = !in_full_reg || exec_go;
    assign cmd_acc   = cmd.valid && cmd.ready;

    assign in_full_next  = cmd_acc || (in_full_reg && !exec_go);
    assign out_full_next = exec_go || (out_full_reg && !rsp.ready);

    ebc_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (exec_go && exec_res.write_valid),
        .waddr   (instr_reg[10:8]),
        .wdata   (exec_res.write_value),
        .re      (cmd_acc),
        .raddr_a (ebc_pkg::opnd_a_addr(cmd.instruction)),
        .raddr_b (ebc_pkg::opnd_b_addr(cmd.instruction)),
        .rdata_a (opa),
        .rdata_b (opb)
    );

    ebc_exec u_exec (
        .instr        (instr_reg),
        .in_byte      (in_byte_reg),
        .in_available (in_avail_reg),
        .opa          (opa),
        .opb          (opb),
        .pc           (pc_reg),
        .flags        (flags_reg),
        .stop         (stop_reg),
        .res          (exec_res)
    );

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            pc_reg       <= '0;
            flags_reg    <= ebc_pkg::FLAGS_RESET;
            stop_reg     <= ebc_pkg::STOP_RUN;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
            if (exec_go)
            begin
                pc_reg    <= exec_res.next_pc;
                flags_reg <= exec_res.flags;
                stop_reg  <= exec_res.run_status;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            instr_reg    <= cmd.instruction;
            in_byte_reg  <= cmd.in_byte;
            in_avail_reg <= cmd.in_available;
        end
        if (exec_go)
        begin
            res_reg <= exec_res;
        end
    end

    assign rsp.valid       = out_full_reg;
    assign rsp.next_pc     = res_reg.next_pc;
    assign rsp.flags       = res_reg.flags;
    assign rsp.write_valid = res_reg.write_valid;
    assign rsp.write_index = res_reg.write_index;
    assign rsp.write_value = res_reg.write_value;
    assign rsp.out_valid   = res_reg.out_valid;
    assign rsp.out_byte    = res_reg.out_byte;
    assign rsp.in_taken    = res_reg.in_taken;
    assign rsp.run_status  = res_reg.run_status;

`ifndef NO_ASSERTIONS
    // once stopped, the stop code never changes again
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg != ebc_pkg::STOP_RUN |=> stop_reg == $past(stop_reg))
        else $error("stop code changed after stop");

    // a stopped block writes no register and keeps its pc
    a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go && stop_reg != ebc_pkg::STOP_RUN |->
            !exec_res.write_valid && !exec_res.out_valid && exec_res.next_pc == pc_reg)
        else $error("stopped block changed state");

    // a consumed input byte is always written to a register
    a_taken_writes: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go && exec_res.in_taken |-> exec_res.write_valid)
        else $error("input byte taken without register write");
`endif

endmodule

FILE: rtl/core/ebc_regfile.sv
// ----------------------------------------------------------------------------
// ebc_regfile - eight-entry register file
// One write port, two registered read ports; a read in the same cycle as a
// write to the same entry returns the new value.
// ----------------------------------------------------------------------------
module ebc_regfile (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              we,
    input  logic [ebc_pkg::REG_AW-1:0]        waddr,
    input  logic [ebc_pkg::DATA_W-1:0]        wdata,
    input  logic                              re,
    input  logic [ebc_pkg::REG_AW-1:0]        raddr_a,
    input  logic [ebc_pkg::REG_AW-1:0]        raddr_b,
    output logic [ebc_pkg::DATA_W-1:0]        rdata_a,
    output logic [ebc_pkg::DATA_W-1:0]        rdata_b
);

    localparam int DEPTH = 2 ** ebc_pkg::REG_AW;

    logic [ebc_pkg::DATA_W-1:0] mem_reg [DEPTH];
    logic [ebc_pkg::DATA_W-1:0] rd_a_reg;
    logic [ebc_pkg::DATA_W-1:0] rd_b_reg;
    logic [ebc_pkg::DATA_W-1:0] rd_a_next;
    logic [ebc_pkg::DATA_W-1:0] rd_b_next;

    // bypass the write in flight
    always_comb
    begin
        rd_a_next = (we && waddr == raddr_a) ? wdata : mem_reg[raddr_a];
        rd_b_next = (we && waddr == raddr_b) ? wdata : mem_reg[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_a_reg <= rd_a_next;
            rd_b_reg <= rd_b_next;
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

FILE: rtl/core/ebc_exec.sv
// ----------------------------------------------------------------------------
// ebc_exec - instruction execute logic
// Decodes one instruction against the fetched operands, pc, flags and stop
// code; gives the result, which also carries the new pc, flags and stop code.
// ----------------------------------------------------------------------------
module ebc_exec (
    input  logic [15:0]                   instr,
    input  logic [ebc_pkg::DATA_W-1:0]    in_byte,
    input  logic                          in_available,
    input  logic [ebc_pkg::DATA_W-1:0]    opa,
    input  logic [ebc_pkg::DATA_W-1:0]    opb,
    input  logic [ebc_pkg::DATA_W-1:0]    pc,
    input  logic [ebc_pkg::FLAG_W-1:0]    flags,
    input  logic [ebc_pkg::STOP_W-1:0]    stop,
    output ebc_pkg::result_t              res
);

    logic [4:0]                  op;
    logic [ebc_pkg::DATA_W-1:0]  imm;
    logic [ebc_pkg::DATA_W-1:0]  pc_inc;
    logic [ebc_pkg::DATA_W-1:0]  pc_jump;
    logic [ebc_pkg::DATA_W:0]    sum;
    logic [ebc_pkg::DATA_W:0]    diff;
    logic [ebc_pkg::DATA_W-1:0]  pc_n;
    logic [ebc_pkg::FLAG_W-1:0]  flags_n;
    logic [ebc_pkg::STOP_W-1:0]  stop_n;
    logic                        wv;
    logic [ebc_pkg::DATA_W-1:0]  wval;
    logic                        ov;
    logic                        taken;

    assign op      = instr[15:11];
    assign imm     = instr[7:0];
    assign pc_inc  = pc + 8'd2;
    assign pc_jump = pc + imm;   // offset wraps, so signed add is plain add
    assign sum     = {1'b0, opa} + {1'b0, opb};
    assign diff    = {1'b0, opa} - {1'b0, opb};

    always_comb
    begin
        pc_n    = pc_inc;
        flags_n = flags;
        stop_n  = stop;
        wv      = 1'b0;
        wval    = '0;
        ov      = 1'b0;
        taken   = 1'b0;

        if (stop == ebc_pkg::STOP_RUN)
        begin
            case (op)
                ebc_pkg::OP_NOP: ;
                ebc_pkg::OP_IN:
                begin
                    if (in_available)
                    begin
                        wv    = 1'b1;
                        wval  = in_byte;
                        taken = 1'b1;
                        flags_n[ebc_pkg::FLAG_EOI] = 1'b0;
                    end
                    else
                    begin
                        flags_n[ebc_pkg::FLAG_EOI] = 1'b1;
                    end
                end
                ebc_pkg::OP_OUT:  ov = 1'b1;
                ebc_pkg::OP_MOV:
                begin
                    wv   = 1'b1;
                    wval = opa;
                end
                ebc_pkg::OP_LDI:
                begin
                    wv   = 1'b1;
                    wval = imm;
                end
                ebc_pkg::OP_JMP:  pc_n = pc_jump;
                ebc_pkg::OP_JZ:   if (flags[ebc_pkg::FLAG_Z])   pc_n = pc_jump;
                ebc_pkg::OP_JNZ:  if (!flags[ebc_pkg::FLAG_Z])  pc_n = pc_jump;
                ebc_pkg::OP_JC:   if (flags[ebc_pkg::FLAG_C])   pc_n = pc_jump;
                ebc_pkg::OP_JO:   if (flags[ebc_pkg::FLAG_O])   pc_n = pc_jump;
                ebc_pkg::OP_JEOI: if (flags[ebc_pkg::FLAG_EOI]) pc_n = pc_jump;
                ebc_pkg::OP_HALT:
                begin
                    stop_n = ebc_pkg::STOP_HALT;
                    pc_n   = pc;
                end
                ebc_pkg::OP_INC:
                begin
                    wv   = 1'b1;
                    wval = opa + 8'd1;
                    flags_n[ebc_pkg::FLAG_C] = (opa == 8'hFF);
                end
                ebc_pkg::OP_DEC:
                begin
                    wv   = 1'b1;
                    wval = opa - 8'd1;
                    flags_n[ebc_pkg::FLAG_C] = (opa == 8'h00);
                end
                ebc_pkg::OP_ADD:
                begin
                    wv   = 1'b1;
                    wval = sum[ebc_pkg::DATA_W-1:0];
                    flags_n[ebc_pkg::FLAG_C] = sum[ebc_pkg::DATA_W];
                    flags_n[ebc_pkg::FLAG_O] = ~(opa[7] ^ opb[7]) & (opa[7] ^ sum[7]);
                end
                ebc_pkg::OP_SUB:
                begin
                    wv   = 1'b1;
                    wval = diff[ebc_pkg::DATA_W-1:0];
                    flags_n[ebc_pkg::FLAG_C] = diff[ebc_pkg::DATA_W];  // borrow
                    flags_n[ebc_pkg::FLAG_O] = (opa[7] ^ opb[7]) & (opa[7] ^ diff[7]);
                end
                ebc_pkg::OP_XOR:
                begin
                    wv   = 1'b1;
                    wval = opa ^ opb;
                end
                ebc_pkg::OP_OR:
                begin
                    wv   = 1'b1;
                    wval = opa | opb;
                end
                ebc_pkg::OP_AND:
                begin
                    wv   = 1'b1;
                    wval = opa & opb;
                end
                ebc_pkg::OP_SHR:
                begin
                    wv   = 1'b1;
                    wval = {1'b0, opa[7:1]};
                    flags_n[ebc_pkg::FLAG_C] = opa[0];
                end
                ebc_pkg::OP_SHL:
                begin
                    wv   = 1'b1;
                    wval = {opa[6:0], 1'b0};
                    flags_n[ebc_pkg::FLAG_C] = opa[7];
                end
                default:
                begin
                    stop_n = ebc_pkg::STOP_FAULT;
                    pc_n   = pc;
                end
            endcase

            if (op inside {[ebc_pkg::OP_INC:ebc_pkg::OP_SHL]})
            begin
                flags_n[ebc_pkg::FLAG_Z] = (wval == 8'h00);
            end
        end
        else
        begin
            pc_n = pc;
        end
    end

    always_comb
    begin
        res.next_pc     = pc_n;
        res.flags       = flags_n;
        res.write_valid = wv;
        res.write_index = wv ? instr[10:8] : '0;
        res.write_value = wval;
        res.out_valid   = ov;
        res.out_byte    = ov ? opa : '0;
        res.in_taken    = taken;
        res.run_status  = stop_n;
    end

endmodule

FILE: test/tb_eight_bit_cpu_execute_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eight_bit_cpu_execute_step - self-checking bench for the execute step
// Drives instruction words with random idle gaps and result back-pressure,
// works out every result word in a local model of the 8-bit machine and
// compares the result stream with it field by field, in order.
// ----------------------------------------------------------------------------
module tb_eight_bit_cpu_execute_step;

    import ebc_pkg::*;

    logic clk;
    logic rst_n;

    ebc_cmd_if cmd ();
    ebc_rsp_if rsp ();

    eight_bit_cpu_execute_step uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // ------------------------------------------------------------------------
    // Machine model state, kept in step with the block at word acceptance
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] shadow_regs [8];
    logic [DATA_W-1:0] shadow_pc;
    logic [FLAG_W-1:0] shadow_flags;
    logic [STOP_W-1:0] shadow_stop;

    // results still owed by the block, oldest first
    result_t pending_results [$];

    // idle control shared by the test tasks and the result-side process
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_cycles;

    int unsigned words_sent;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned rx_holds_done;
    logic [STOP_W-1:0] final_stop;

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous overall limit; a correct run needs a small fraction of this.
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of one executed word. Updates the shadow state and returns the
    // result word the block must produce for it.
    // ------------------------------------------------------------------------
    function automatic result_t execute_word(input logic [15:0] instr,
                                             input logic [7:0]  inb,
                                             input logic        avail);
        result_t           res;
        logic [4:0]        op;
        logic [2:0]        rd, rs, rt;
        logic              three_reg;
        logic [7:0]        imm, opa, opb, wval, obyte, pc_nxt, pc_jump;
        logic [8:0]        wide_sum;
        logic              wr, emit, took;

        op        = instr[15:11];
        rd        = instr[10:8];
        three_reg = instr[7];
        rs        = instr[6:4];
        rt        = instr[2:0];
        imm       = instr[7:0];
        pc_nxt    = shadow_pc + 8'd2;
        pc_jump   = shadow_pc + imm;      // signed offset wraps the same way
        opa       = three_reg ? shadow_regs[rs] : shadow_regs[rd];
        opb       = three_reg ? shadow_regs[rt] : shadow_regs[rs];
        wr        = 1'b0;
        emit      = 1'b0;
        took      = 1'b0;
        wval      = '0;
        obyte     = '0;

        if (shadow_stop == STOP_RUN)
        begin
            case (op)
                OP_NOP: ;
                OP_IN:
                begin
                    if (avail)
                    begin
                        wr   = 1'b1;
                        wval = inb;
                        took = 1'b1;
                        shadow_flags[FLAG_EOI] = 1'b0;
                    end
                    else
                        shadow_flags[FLAG_EOI] = 1'b1;
                end
                OP_OUT:
                begin
                    emit  = 1'b1;
                    obyte = shadow_regs[rs];
                end
                OP_MOV:
                begin
                    wr   = 1'b1;
                    wval = shadow_regs[rs];
                end
                OP_LDI:
                begin
                    wr   = 1'b1;
                    wval = imm;
                end
                OP_JMP:  pc_nxt = pc_jump;
                OP_JZ:   if (shadow_flags[FLAG_Z])   pc_nxt = pc_jump;
                OP_JNZ:  if (!shadow_flags[FLAG_Z])  pc_nxt = pc_jump;
                OP_JC:   if (shadow_flags[FLAG_C])   pc_nxt = pc_jump;
                OP_JO:   if (shadow_flags[FLAG_O])   pc_nxt = pc_jump;
                OP_JEOI: if (shadow_flags[FLAG_EOI]) pc_nxt = pc_jump;
                OP_HALT:
                begin
                    shadow_stop = STOP_HALT;
                    pc_nxt      = shadow_pc;
                end
                OP_INC:
                begin
                    wr   = 1'b1;
                    wval = shadow_regs[rd] + 8'd1;
                    shadow_flags[FLAG_C] = (shadow_regs[rd] == 8'hFF);
                end
                OP_DEC:
                begin
                    wr   = 1'b1;
                    wval = shadow_regs[rd] - 8'd1;
                    shadow_flags[FLAG_C] = (shadow_regs[rd] == 8'h00);
                end
                OP_ADD:
                begin
                    wide_sum = {1'b0, opa} + {1'b0, opb};
                    wr       = 1'b1;
                    wval     = wide_sum[7:0];
                    shadow_flags[FLAG_C] = wide_sum[8];
                    shadow_flags[FLAG_O] = ~(opa[7] ^ opb[7]) & (opa[7] ^ wval[7]);
                end
                OP_SUB:
                begin
                    wr   = 1'b1;
                    wval = opa - opb;
                    shadow_flags[FLAG_C] = (opa < opb);
                    shadow_flags[FLAG_O] = (opa[7] ^ opb[7]) & (opa[7] ^ wval[7]);
                end
                OP_XOR:
                begin
                    wr   = 1'b1;
                    wval = opa ^ opb;
                end
                OP_OR:
                begin
                    wr   = 1'b1;
                    wval = opa | opb;
                end
                OP_AND:
                begin
                    wr   = 1'b1;
                    wval = opa & opb;
                end
                OP_SHR:
                begin
                    wr   = 1'b1;
                    wval = shadow_regs[rs] >> 1;
                    shadow_flags[FLAG_C] = shadow_regs[rs][0];
                end
                OP_SHL:
                begin
                    wr   = 1'b1;
                    wval = shadow_regs[rs] << 1;
                    shadow_flags[FLAG_C] = shadow_regs[rs][7];
                end
                default:
                begin
                    shadow_stop = STOP_FAULT;
                    pc_nxt      = shadow_pc;
                end
            endcase
            // ALU class sets zero from the written value
            if (op >= OP_INC && op <= OP_SHL)
                shadow_flags[FLAG_Z] = (wval == 8'h00);
            if (wr)
                shadow_regs[rd] = wval;
            shadow_pc = pc_nxt;
        end

        res.next_pc     = shadow_pc;
        res.flags       = shadow_flags;
        res.write_valid = wr;
        res.write_index = wr ? rd : '0;
        res.write_value = wr ? wval : '0;
        res.out_valid   = emit;
        res.out_byte    = emit ? obyte : '0;
        res.in_taken    = took;
        res.run_status  = shadow_stop;
        return res;
    endfunction

    function automatic string show_result(input result_t r);
        return $sformatf("pc=%h flags=%b wr=%b/%0d/%h out=%b/%h in=%b stat=%0d",
                         r.next_pc, r.flags, r.write_valid, r.write_index,
                         r.write_value, r.out_valid, r.out_byte, r.in_taken,
                         r.run_status);
    endfunction

    // ------------------------------------------------------------------------
    // Instruction encoders and random choices
    // ------------------------------------------------------------------------
    function automatic logic [15:0] enc_rr(input logic [4:0] op, input logic [2:0] rd,
                                           input logic [2:0] rs);
        return {op, rd, 1'b0, rs, 4'b0000};
    endfunction

    function automatic logic [15:0] enc_rrr(input logic [4:0] op, input logic [2:0] rd,
                                            input logic [2:0] rs, input logic [2:0] rt);
        return {op, rd, 1'b1, rs, 1'b0, rt};
    endfunction

    function automatic logic [15:0] enc_imm(input logic [4:0] op, input logic [2:0] rd,
                                            input logic [7:0] imm);
        return {op, rd, imm};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // byte values that sit on carry, overflow and zero boundaries
    function automatic logic [7:0] corner_byte();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    // any opcode that keeps the machine running; load immediate favoured
    // so the registers keep picking up fresh values
    function automatic logic [4:0] pick_opcode();
        logic [4:0] op;
        if ($urandom_range(0, 3) == 0)
            return OP_LDI;
        op = 5'($urandom_range(OP_NOP, OP_SHR));
        if (op == OP_HALT)
            op = OP_SHL;
        return op;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one word per call. Valid is left high when no gap follows, so
    // back-to-back words never lower and raise it in the same step.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [15:0] instr, input logic [7:0] inb,
                             input logic avail);
        int gap;
        cmd.valid        <= 1'b1;
        cmd.instruction  <= instr;
        cmd.in_byte      <= inb;
        cmd.in_available <= avail;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        pending_results.push_back(execute_word(instr, inb, avail));
        words_sent++;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = pick_gap();
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_word();
        logic [15:0] instr;
        logic [4:0]  op;
        op    = pick_opcode();
        instr = 16'($urandom_range(0, 16'hFFFF));
        instr[15:11] = op;
        if (op == OP_LDI && $urandom_range(0, 1) == 1)
            instr[7:0] = corner_byte();
        send_word(instr, 8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // drop valid and hold off until every owed result has come back
    task automatic park_sender();
        cmd.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready with random stalls, plus long hold-offs on request,
    // counted here in cycles.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int span;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                rsp.ready <= 1'b0;
                span = rx_hold_cycles;
                rx_hold_cycles = 0;
                repeat (span) @(posedge clk);
                rx_holds_done++;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                span = pick_gap();
                repeat (span) @(posedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Each accepted result word against the oldest owed one
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.next_pc     = rsp.next_pc;
            got.flags       = rsp.flags;
            got.write_valid = rsp.write_valid;
            got.write_index = rsp.write_index;
            got.write_value = rsp.write_value;
            got.out_valid   = rsp.out_valid;
            got.out_byte    = rsp.out_byte;
            got.in_taken    = rsp.in_taken;
            got.run_status  = rsp.run_status;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %s", show_result(got));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.next_pc     !== want.next_pc     ||
                    got.flags       !== want.flags       ||
                    got.write_valid !== want.write_valid ||
                    got.write_index !== want.write_index ||
                    got.write_value !== want.write_value ||
                    got.out_valid   !== want.out_valid   ||
                    got.out_byte    !== want.out_byte    ||
                    got.in_taken    !== want.in_taken    ||
                    got.run_status  !== want.run_status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch on result %0d", results_checked);
                        $display("  expected %s", show_result(want));
                        $display("  actual   %s", show_result(got));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Short walk through every running opcode and the flag corner cases:
    // carry and zero on add, signed overflow on add and subtract, borrow,
    // input with and without a byte, increment and decrement wrap, and the
    // most negative jump offset.
    task automatic test_directed();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_word(enc_imm(OP_LDI, 3'd0, 8'hFF), 8'h00, 1'b1);
        send_word(enc_imm(OP_LDI, 3'd1, 8'h01), 8'hFF, 1'b0);
        send_word(enc_rr(OP_ADD, 3'd0, 3'd1), 8'h55, 1'b1);         // FF+01: carry, zero
        send_word(enc_imm(OP_JC, 3'd0, 8'h04), 8'hAA, 1'b1);
        send_word(enc_imm(OP_JZ, 3'd7, 8'h06), 8'h00, 1'b0);
        send_word(enc_imm(OP_LDI, 3'd2, 8'h7F), 8'h00, 1'b1);
        send_word(enc_rrr(OP_ADD, 3'd3, 3'd2, 3'd1), 8'h00, 1'b1);  // 7F+01: overflow
        send_word(enc_imm(OP_JO, 3'd0, 8'hFE), 8'h00, 1'b1);
        send_word(enc_rrr(OP_SUB, 3'd4, 3'd0, 3'd1), 8'h00, 1'b1);  // 00-01: borrow
        send_word(enc_rr(OP_SUB, 3'd3, 3'd1), 8'h00, 1'b1);         // 80-01: overflow
        send_word(enc_imm(OP_JNZ, 3'd0, 8'h08), 8'h00, 1'b1);
        send_word(enc_rr(OP_IN, 3'd5, 3'd0), 8'hFF, 1'b1);          // byte taken
        send_word(enc_rr(OP_IN, 3'd6, 3'd0), 8'h3C, 1'b0);          // stream ended
        send_word(enc_imm(OP_JEOI, 3'd0, 8'h7F), 8'h00, 1'b1);
        send_word(enc_rr(OP_OUT, 3'd0, 3'd5), 8'h00, 1'b1);
        send_word(enc_rr(OP_MOV, 3'd7, 3'd3), 8'h00, 1'b1);
        send_word(enc_rrr(OP_XOR, 3'd0, 3'd5, 3'd3), 8'h00, 1'b1);
        send_word(enc_rr(OP_OR, 3'd1, 3'd7), 8'h00, 1'b1);
        send_word(enc_rrr(OP_AND, 3'd2, 3'd5, 3'd3), 8'h00, 1'b1);
        send_word(enc_rr(OP_SHR, 3'd4, 3'd1), 8'h00, 1'b1);
        send_word(enc_rr(OP_SHL, 3'd0, 3'd5), 8'h00, 1'b1);
        send_word(enc_rr(OP_INC, 3'd5, 3'd0), 8'h00, 1'b1);         // FF wraps to 00
        send_word(enc_rr(OP_DEC, 3'd6, 3'd0), 8'h00, 1'b1);         // 00 wraps to FF
        send_word(enc_rr(OP_NOP, 3'd0, 3'd0), 8'h00, 1'b1);
        send_word(enc_imm(OP_JMP, 3'd0, 8'h80), 8'h00, 1'b1);
    endtask

    // Random running words in stretches of 40, idling switched per stretch
    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_random_word();
        end
    endtask

    // Full rate both sides, no gaps at all
    task automatic test_full_rate(input int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (count) send_random_word();
    endtask

    // Result side holds off for a long stretch while words keep coming,
    // so the output buffer and the input stage both fill and cmd stalls
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_cycles = $urandom_range(40, 80);
        repeat (40) send_random_word();
        rx_idle_on = 1'b1;
    endtask

    // Bursts separated by a full drain of the pipeline
    task automatic test_sender_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (4)
        begin
            repeat ($urandom_range(10, 25)) send_random_word();
            park_sender();
        end
    endtask

    // Stop the machine with halt or an unknown opcode, then check that any
    // later word, including more halts and unknown opcodes, changes nothing.
    task automatic test_stopped();
        logic [15:0] instr;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        instr = 16'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 1) == 1)
            instr[15:11] = OP_HALT;
        else
            instr[15:11] = 5'($urandom_range(OP_SHL + 1, 5'h1F));
        send_word(instr, 8'($urandom_range(0, 255)), 1'b1);
        final_stop = shadow_stop;
        repeat (35)
            send_word(16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 1) == 1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;
        shadow_pc      = '0;
        shadow_flags   = FLAGS_RESET;
        shadow_stop    = STOP_RUN;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = 0;

        rst_n            <= 1'b0;
        cmd.valid        <= 1'b0;
        cmd.instruction  <= '0;
        cmd.in_byte      <= '0;
        cmd.in_available <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(320);
        test_full_rate(150);
        test_backpressure();
        test_sender_pause();
        test_stopped();

        // drain, then idle on to catch any stray result word
        park_sender();
        repeat (10) @(posedge clk);

        $display("%0d instruction words sent, %0d result words checked, %0d long hold-offs",
                 words_sent, results_checked, rx_holds_done);
        $display("machine stopped with status %0d; %0d mismatches", final_stop, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
